// ===== rtl/ctts_pkg.sv =====
`timescale 1ns / 1ps

package ctts_pkg;

    localparam int VERTEX_BITS = 31;
    localparam int ID_W        = 31;
    localparam int CNT_W       = 31;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [2:0]       t_face;
    typedef logic [2:0]       t_cidx;
    typedef logic [3:0][ID_W-1:0] t_quad;

    localparam t_id ID_MASK = (VERTEX_BITS >= ID_W) ? {ID_W{1'b1}}
                            : t_id'((64'd1 << VERTEX_BITS) - 64'd1);
    localparam t_cnt CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] SHAPE_TET     = 2'd0;
    localparam logic [1:0] SHAPE_HEX     = 2'd1;
    localparam logic [1:0] SHAPE_PRISM   = 2'd2;
    localparam logic [1:0] SHAPE_PYRAMID = 2'd3;

    localparam t_cidx HEX_FACES [6][4] = '{
        '{3'd0, 3'd3, 3'd2, 3'd1}, '{3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd0, 3'd1, 3'd5, 3'd4}, '{3'd1, 3'd2, 3'd6, 3'd5},
        '{3'd2, 3'd3, 3'd7, 3'd6}, '{3'd3, 3'd0, 3'd4, 3'd7}
    };
    localparam t_cidx PRISM_FACES [5][4] = '{
        '{3'd0, 3'd2, 3'd1, 3'd0}, '{3'd3, 3'd4, 3'd5, 3'd0},
        '{3'd0, 3'd1, 3'd4, 3'd3}, '{3'd1, 3'd2, 3'd5, 3'd4},
        '{3'd2, 3'd0, 3'd3, 3'd5}
    };
    localparam t_cidx PYRAMID_FACES [5][4] = '{
        '{3'd0, 3'd3, 3'd2, 3'd1}, '{3'd0, 3'd1, 3'd4, 3'd0},
        '{3'd1, 3'd2, 3'd4, 3'd0}, '{3'd2, 3'd3, 3'd4, 3'd0},
        '{3'd3, 3'd0, 3'd4, 3'd0}
    };

    typedef enum logic [2:0] {
        SEL_TET,
        SEL_AC_FIRST,
        SEL_AC_SECOND,
        SEL_BD_FIRST,
        SEL_BD_SECOND
    } t_emit_sel;

    typedef struct packed {
        logic      busy;
        logic      cmp;
        logic      emit;
        logic      last;
        t_emit_sel sel;
        t_face     face;
    } t_seq_ctrl;

    typedef struct packed {
        logic [1:0] cell_shape;
        t_id        corner_0;
        t_id        corner_1;
        t_id        corner_2;
        t_id        corner_3;
        t_id        corner_4;
        t_id        corner_5;
        t_id        corner_6;
        t_id        corner_7;
        t_id        center_vertex;
    } t_cell_in;

    typedef struct packed {
        t_id  tet_apex;
        t_id  tet_b;
        t_id  tet_c;
        t_id  tet_d;
        t_cnt tet_number;
        logic last_of_cell;
    } t_tet_out;

    function automatic t_id vid(input t_id x);
        return x & ID_MASK;
    endfunction

    function automatic t_face num_faces(input logic [1:0] shape);
        t_face n;
        case (shape)
            SHAPE_TET: n = 3'd1;
            SHAPE_HEX: n = 3'd6;
            default:   n = 3'd5;
        endcase
        return n;
    endfunction

    function automatic logic face_is_quad(input logic [1:0] shape, input t_face face);
        logic q;
        case (shape)
            SHAPE_HEX:     q = 1'b1;
            SHAPE_PRISM:   q = (face >= 3'd2);
            SHAPE_PYRAMID: q = (face == 3'd0);
            default:       q = 1'b0;
        endcase
        return q;
    endfunction

    function automatic t_cidx face_corner(input logic [1:0] shape, input t_face face,
                                          input logic [1:0] j);
        t_cidx idx;
        case (shape)
            SHAPE_HEX:     idx = HEX_FACES[face][j];
            SHAPE_PRISM:   idx = PRISM_FACES[face][j];
            SHAPE_PYRAMID: idx = PYRAMID_FACES[face][j];
            default:       idx = {1'b0, j};
        endcase
        return idx;
    endfunction

endpackage

// ===== rtl/ctts_diag.sv =====
`timescale 1ns / 1ps

module ctts_diag import ctts_pkg::*; (
    input  t_quad i_face,
    output logic  o_ac_first
);

    t_id ac_lo;
    t_id ac_hi;
    t_id bd_lo;
    t_id bd_hi;

    always_comb begin
        ac_lo = (i_face[0] < i_face[2]) ? i_face[0] : i_face[2];
        ac_hi = (i_face[0] < i_face[2]) ? i_face[2] : i_face[0];
        bd_lo = (i_face[1] < i_face[3]) ? i_face[1] : i_face[3];
        bd_hi = (i_face[1] < i_face[3]) ? i_face[3] : i_face[1];
        o_ac_first = (ac_lo < bd_lo) || ((ac_lo == bd_lo) && (ac_hi < bd_hi));
    end

endmodule

// ===== rtl/ctts_seq.sv =====
`timescale 1ns / 1ps

module ctts_seq import ctts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_shape,
    input  logic       i_ac_first,
    input  logic       i_out_free,
    output t_seq_ctrl  o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EMIT0,
        S_EMIT1
    } t_state;

    t_state     r_state;
    logic [1:0] r_shape;
    t_face      r_face;
    logic       r_ac_first;

    t_face n_face;
    logic  quad;
    logic  last_face;
    logic  next_quad;

    always_comb begin
        n_face    = r_face + 3'd1;
        quad      = face_is_quad(r_shape, r_face);
        next_quad = face_is_quad(r_shape, n_face);
        last_face = (r_face == num_faces(r_shape) - 3'd1);

        o_ctrl.busy = (r_state != S_IDLE);
        o_ctrl.cmp  = (r_state == S_CMP);
        o_ctrl.emit = ((r_state == S_EMIT0) || (r_state == S_EMIT1)) && i_out_free;
        o_ctrl.last = last_face && ((r_state == S_EMIT1) || ((r_state == S_EMIT0) && !quad));
        o_ctrl.face = r_face;
        if (r_state == S_EMIT1) begin
            o_ctrl.sel = r_ac_first ? SEL_AC_SECOND : SEL_BD_SECOND;
        end else if (r_shape == SHAPE_TET) begin
            o_ctrl.sel = SEL_TET;
        end else if (!quad || r_ac_first) begin
            o_ctrl.sel = SEL_AC_FIRST;
        end else begin
            o_ctrl.sel = SEL_BD_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_shape <= i_shape;
                        r_face  <= 3'd0;
                        r_state <= face_is_quad(i_shape, 3'd0) ? S_CMP : S_EMIT0;
                    end
                end
                S_CMP: begin
                    r_ac_first <= i_ac_first;
                    r_state    <= S_EMIT0;
                end
                S_EMIT0, S_EMIT1: begin
                    if (i_out_free) begin
                        if (r_state == S_EMIT0 && quad) begin
                            r_state <= S_EMIT1;
                        end else if (last_face) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_face  <= n_face;
                            r_state <= next_quad ? S_CMP : S_EMIT0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/cell_to_tetra_splitter.sv =====
`timescale 1ns / 1ps

// Splits one volume cell into tetrahedra coned to the cell's center vertex;
// a tetrahedron cell is passed on as itself. Input channel: i_valid / o_stall
// carry one cell beat (t_cell_in). The block raises o_stall from the beat
// after acceptance until its last tetrahedron has been loaded into the output register.
// Output channel: o_valid / i_stall carry one tetrahedron beat (t_tet_out);
// last_of_cell marks the final tetrahedron of a cell.
// Sequence: one shared diagonal compare unit is used for each quad face; a
// quad face passes the compare state (S_CMP) and then emits two tetrahedra
// split along the chosen diagonal, and a triangle face emits one tetrahedron.
// The first result is registered without a compare state for a tetrahedron
// or prism, and after the compare state for a hexahedron or pyramid.
// Receiver stall: the output register holds its beat and the sequencer waits;
// the next cell is taken while the final beat of a cell still waits.
// Reset: synchronous, active low; clears the sequencer, the output valid and
// the running tetrahedron number, which saturates at its maximum.

module cell_to_tetra_splitter import ctts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_cell_in i_cell,
    output logic     o_valid,
    input  logic     i_stall,
    output t_tet_out o_tet
);

    t_seq_ctrl ctrl;
    t_cell_in  r_cell;
    t_tet_out  r_out;
    logic      r_out_valid;
    t_cnt      r_cnt;

    t_cnt     n_cnt;
    t_tet_out n_out;
    logic     start;
    logic     out_free;
    logic     ac_first;
    t_id      corner [8];
    t_id      center;
    t_quad    face;

    assign start    = i_valid && !ctrl.busy;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = ctrl.busy;
    assign o_valid  = r_out_valid;
    assign o_tet    = r_out;

    always_comb begin
        corner[0] = vid(r_cell.corner_0);
        corner[1] = vid(r_cell.corner_1);
        corner[2] = vid(r_cell.corner_2);
        corner[3] = vid(r_cell.corner_3);
        corner[4] = vid(r_cell.corner_4);
        corner[5] = vid(r_cell.corner_5);
        corner[6] = vid(r_cell.corner_6);
        corner[7] = vid(r_cell.corner_7);
        center    = vid(r_cell.center_vertex);
        for (int j = 0; j < 4; j++) begin
            face[j] = corner[face_corner(r_cell.cell_shape, ctrl.face, 2'(j))];
        end
    end

    ctts_diag u_diag (
        .i_face     (face),
        .o_ac_first (ac_first)
    );

    ctts_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_shape    (i_cell.cell_shape),
        .i_ac_first (ac_first),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    always_comb begin
        n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
        n_out.tet_apex     = center;
        n_out.tet_b        = face[0];
        n_out.tet_c        = face[1];
        n_out.tet_d        = face[2];
        n_out.tet_number   = n_cnt;
        n_out.last_of_cell = ctrl.last;
        case (ctrl.sel)
            SEL_TET: begin
                n_out.tet_apex = face[0];
                n_out.tet_b    = face[1];
                n_out.tet_c    = face[2];
                n_out.tet_d    = face[3];
            end
            SEL_AC_FIRST: begin
                n_out.tet_b = face[0];
                n_out.tet_c = face[1];
                n_out.tet_d = face[2];
            end
            SEL_AC_SECOND: begin
                n_out.tet_b = face[0];
                n_out.tet_c = face[2];
                n_out.tet_d = face[3];
            end
            SEL_BD_FIRST: begin
                n_out.tet_b = face[1];
                n_out.tet_c = face[2];
                n_out.tet_d = face[3];
            end
            SEL_BD_SECOND: begin
                n_out.tet_b = face[1];
                n_out.tet_c = face[3];
                n_out.tet_d = face[0];
            end
            default: begin
                n_out.tet_b = face[0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cell <= i_cell;
        end
        if (ctrl.emit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
            r_cnt       <= n_cnt;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after cell accept");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.emit && ctrl.last) |=> !o_stall)
        else $error("block still busy after last tetrahedron");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.emit && r_cnt != CNT_MAX) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("tetrahedron number did not advance");

    a_emit_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> (ctrl.busy && !ctrl.cmp))
        else $error("tetrahedron emitted outside emit phase");

endmodule
